// ----- hw/rtl/dwg_pkg.sv -----
`timescale 1ns / 1ps

package dwg_pkg;

  // Default build values
  localparam int DEF_TABLE_DEPTH     = 16384;
  localparam int DEF_PHASE_FRAC_BITS = 48;
  localparam int DEF_SAMPLE_BITS     = 16;

  // Register widths
  localparam int PERIOD_W = 15;
  localparam int OVER_W   = 5;
  localparam int RATE_W   = 48;
  localparam int GSTART_W = 24;
  localparam int GAIN_W   = 48;

  // Item field widths
  localparam int ADDR_W       = 14;
  localparam int VALUE_W      = 16;
  localparam int SAMPLE_OUT_W = 24;
  localparam int INDEX_W      = 14;
  localparam int VEXT_W       = 24;

  // Limits and fixed-point shifts
  localparam int PERIOD_MAX = 16384;
  localparam int OVER_MAX   = 16;
  localparam int INT_W      = 14;  // integer bits of the phase
  localparam int RAW_W      = 18;  // unreduced table index
  localparam int GAIN_ALIGN = 24;  // Q8.16 to Q8.40
  localparam int OUT_SHIFT  = 40;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_COUNT  = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD      = 3'd0,
    CFG_OVERSAMPLE  = 3'd1,
    CFG_RATE_OFFSET = 3'd2,
    CFG_RATE_DRIFT  = 3'd3,
    CFG_GAIN_START  = 3'd4,
    CFG_GAIN_SLOPE  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                      func;
    logic [ADDR_W-1:0]         table_addr;
    logic signed [VALUE_W-1:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_OUT_W-1:0] sample_out;
    logic [INDEX_W-1:0]             table_index;
  } out_item_t;

  typedef struct packed {
    logic cfg_wr;
    logic restart;
    logic accept_tick;
    logic accept_load;
    logic quo_en;
    logic rem_rd;
    logic rem_wr;
    logic mul_en;
    logic sum_en;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hw/rtl/dwg_ctrl.sv -----
`timescale 1ns / 1ps

module dwg_ctrl import dwg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_func,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  dp_sts_t              sts,
  output logic                 in_stall,
  output logic                 cfg_ready,
  output dp_cmd_t              cmd
);

  typedef enum logic [2:0] {
    ST_RESTART,
    ST_IDLE,
    ST_QUO,
    ST_REM,
    ST_MUL,
    ST_SUM
  } state_t;

  state_t state_r, state_nxt;
  logic   is_tick_r, is_tick_nxt;
  logic   cfg_known;

  assign cfg_known = (cfg_index < CFG_IDX_W'(CFG_COUNT));

  // Sequence one beat at a time through the shared datapath
  always_comb begin
    state_nxt   = state_r;
    is_tick_nxt = is_tick_r;
    cmd         = '0;
    in_stall    = 1'b1;
    cfg_ready   = 1'b0;
    unique case (state_r)
      ST_RESTART: begin
        cmd.restart = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_IDLE: begin
        cfg_ready  = 1'b1;
        in_stall   = cfg_valid;
        cmd.cfg_wr = cfg_valid;
        if (cfg_valid) begin
          if (cfg_known) begin
            state_nxt = ST_RESTART;
          end
        end else if (in_valid) begin
          cmd.accept_tick = in_func;
          cmd.accept_load = !in_func;
          is_tick_nxt     = in_func;
          state_nxt       = ST_QUO;
        end
      end
      ST_QUO: begin
        cmd.quo_en = 1'b1;
        state_nxt  = ST_REM;
      end
      ST_REM: begin
        if (is_tick_r) begin
          cmd.rem_rd = 1'b1;
          state_nxt  = ST_MUL;
        end else begin
          cmd.rem_wr = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          cmd.sum_en = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_RESTART;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RESTART;
      is_tick_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      is_tick_r <= is_tick_nxt;
    end
  end

endmodule

// ----- hw/rtl/dwg_datapath.sv -----
`timescale 1ns / 1ps

module dwg_datapath import dwg_pkg::*; #(
  parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH,
  parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS,
  parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  in_item_t              in_data,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_item_t             out_data
);

  localparam int F       = PHASE_FRAC_BITS;
  localparam int PS_W    = INT_W + F;
  localparam int MW      = PS_W + 1;
  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int K       = RAW_W + IDX_W;
  localparam int QP_W    = 2 * RAW_W + 1 + IDX_W;
  localparam int RP_W    = RAW_W + IDX_W + 1;
  localparam int SB      = SAMPLE_BITS;
  localparam int PHI_W   = SB + GSTART_W;
  localparam int PLO_W   = SB + GAIN_ALIGN + 1;
  localparam int FULL_W  = SB + GAIN_W + 1;
  localparam int PPROD_W = PS_W + OVER_W;

  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << K) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
  localparam logic [RAW_W:0] RECIP = RECIP_FULL[RAW_W:0];
  localparam logic [MW:0]    ONE_X = (MW+1)'(1) << F;

  localparam logic signed [FULL_W-1:0] OUT_MAX_X = FULL_W'((1 << (SAMPLE_OUT_W-1)) - 1);
  localparam logic signed [FULL_W-1:0] OUT_MIN_X = FULL_W'(-(1 << (SAMPLE_OUT_W-1)));
  localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

  // Configuration registers
  logic [PERIOD_W-1:0] period_r;
  logic [OVER_W-1:0]   over_r;
  logic [RATE_W-1:0]   alpha_r;
  logic [RATE_W-1:0]   beta_r;
  logic [GSTART_W-1:0] gstart_r;
  logic [GAIN_W-1:0]   gslope_r;

  // Accumulators and pipeline registers
  logic [PS_W-1:0]          phase_acc_r;
  logic [PS_W-1:0]          phase_step_r;
  logic [PS_W-1:0]          drift_inc_r;
  logic [GAIN_W-1:0]        gain_acc_r;
  logic [GAIN_W-1:0]        gain_cap_r;
  logic [RAW_W-1:0]         raw_r;
  logic [RAW_W-1:0]         quo_r;
  logic [IDX_W-1:0]         idx_r;
  logic [SB-1:0]            wval_r;
  logic signed [SB-1:0]     word_r;
  logic signed [PHI_W-1:0]  phi_r;
  logic signed [PLO_W-1:0]  plo_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  logic [SB-1:0] table_mem [TABLE_DEPTH];

  // Combinational signals
  logic [PERIOD_W-1:0]      period_used;
  logic [OVER_W-1:0]        over_used;
  logic [MW-1:0]            modulus;
  logic signed [F-1:0]      alpha_f;
  logic signed [F-1:0]      beta_f;
  logic signed [MW:0]       a_x;
  logic signed [MW:0]       b_x;
  logic signed [MW:0]       sum0;
  logic [MW-1:0]            sum0_u;
  logic [MW-1:0]            step_init;
  logic signed [MW:0]       dv;
  logic signed [MW:0]       drift_w;
  logic [MW-1:0]            acc_sum;
  logic [MW-1:0]            acc_nxt;
  logic [MW-1:0]            step_sum;
  logic [MW-1:0]            step_nxt;
  logic [GAIN_W:0]          gsum;
  logic [GAIN_W-1:0]        gain_adv;
  logic [PPROD_W-1:0]       phase_prod;
  logic [RAW_W-1:0]         raw_tick;
  logic signed [VEXT_W-1:0] v_ext;
  logic [QP_W-1:0]          qprod;
  logic [RP_W-1:0]          rprod;
  logic [RP_W-1:0]          rem_full;
  logic [IDX_W-1:0]         rem_idx;
  logic signed [GSTART_W-1:0] gain_hi;
  logic signed [GAIN_ALIGN:0] gain_lo;
  logic signed [PHI_W-1:0]  phi;
  logic signed [PLO_W-1:0]  plo;
  logic signed [FULL_W-1:0] full;
  logic signed [FULL_W-1:0] y_sh;
  logic [SAMPLE_OUT_W-1:0]  sample_sat;
  logic [31:0]              idx_ext;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_W'(PERIOD_MAX);
      over_r   <= OVER_W'(1);
      alpha_r  <= '0;
      beta_r   <= '0;
      gstart_r <= GSTART_W'(65536);
      gslope_r <= '0;
    end else if (cmd.cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PERIOD:      period_r <= cfg_data[PERIOD_W-1:0];
        CFG_OVERSAMPLE:  over_r   <= cfg_data[OVER_W-1:0];
        CFG_RATE_OFFSET: alpha_r  <= cfg_data[RATE_W-1:0];
        CFG_RATE_DRIFT:  beta_r   <= cfg_data[RATE_W-1:0];
        CFG_GAIN_START:  gstart_r <= cfg_data[GSTART_W-1:0];
        CFG_GAIN_SLOPE:  gslope_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp period and oversample, form the phase modulus
  always_comb begin
    if (period_r == '0) begin
      period_used = PERIOD_W'(1);
    end else if (period_r > PERIOD_W'(PERIOD_MAX)) begin
      period_used = PERIOD_W'(PERIOD_MAX);
    end else begin
      period_used = period_r;
    end
    if (over_r == '0) begin
      over_used = OVER_W'(1);
    end else if (over_r > OVER_W'(OVER_MAX)) begin
      over_used = OVER_W'(OVER_MAX);
    end else begin
      over_used = over_r;
    end
  end

  assign modulus = {period_used, {F{1'b0}}};

  // Restart values: step = (1 + alpha + beta) mod M, drift = (2 beta) mod M
  assign alpha_f   = alpha_r[RATE_W-1 -: F];
  assign beta_f    = beta_r[RATE_W-1 -: F];
  assign a_x       = (MW+1)'(alpha_f);
  assign b_x       = (MW+1)'(beta_f);
  assign sum0      = $signed(ONE_X) + a_x + b_x;
  assign sum0_u    = sum0[MW-1:0];
  assign step_init = (sum0_u >= modulus) ? (sum0_u - modulus) : sum0_u;
  assign dv        = b_x <<< 1;
  assign drift_w   = dv[MW] ? ($signed({1'b0, modulus}) + dv) : dv;

  // Advance the second-order phase recurrence
  assign acc_sum  = {1'b0, phase_acc_r} + {1'b0, phase_step_r};
  assign acc_nxt  = (acc_sum >= modulus) ? (acc_sum - modulus) : acc_sum;
  assign step_sum = {1'b0, phase_step_r} + {1'b0, drift_inc_r};
  assign step_nxt = (step_sum >= modulus) ? (step_sum - modulus) : step_sum;

  // Advance the gain with saturation
  assign gsum     = {gain_acc_r[GAIN_W-1], gain_acc_r} + {gslope_r[GAIN_W-1], gslope_r};
  assign gain_adv = (gsum[GAIN_W] != gsum[GAIN_W-1]) ?
                    (gsum[GAIN_W] ? GAIN_MIN : GAIN_MAX) : gsum[GAIN_W-1:0];

  // Unreduced table index: floor(phase * oversample)
  assign phase_prod = PPROD_W'(phase_acc_r) * PPROD_W'(over_used);
  assign raw_tick   = phase_prod[F +: RAW_W];

  assign v_ext = VEXT_W'(in_data.table_value);

  // Accumulators and beat capture
  always_ff @(posedge clk) begin
    if (cmd.restart) begin
      phase_acc_r  <= '0;
      phase_step_r <= step_init[PS_W-1:0];
      drift_inc_r  <= drift_w[PS_W-1:0];
      gain_acc_r   <= {gstart_r, {GAIN_ALIGN{1'b0}}};
    end
    if (cmd.accept_tick) begin
      raw_r        <= raw_tick;
      gain_cap_r   <= gain_acc_r;
      phase_acc_r  <= acc_nxt[PS_W-1:0];
      phase_step_r <= step_nxt[PS_W-1:0];
      gain_acc_r   <= gain_adv;
    end
    if (cmd.accept_load) begin
      raw_r  <= RAW_W'(in_data.table_addr);
      wval_r <= v_ext[SB-1:0];
    end
  end

  // Reduce the index modulo the table depth by reciprocal multiply
  assign qprod    = QP_W'(raw_r) * QP_W'(RECIP);
  assign rprod    = RP_W'(quo_r) * RP_W'(TABLE_DEPTH);
  assign rem_full = RP_W'(raw_r) - rprod;
  assign rem_idx  = rem_full[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.quo_en) begin
      quo_r <= qprod[K +: RAW_W];
    end
    if (cmd.rem_rd) begin
      idx_r <= rem_idx;
    end
  end

  // Waveform table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.rem_wr) begin
      table_mem[rem_idx] <= wval_r;
    end
    if (cmd.rem_rd) begin
      word_r <= table_mem[rem_idx];
    end
  end

  // Split the gain into high and low halves for two narrow products
  assign gain_hi = gain_cap_r[GAIN_W-1 -: GSTART_W];
  assign gain_lo = $signed({1'b0, gain_cap_r[GAIN_ALIGN-1:0]});
  assign phi     = word_r * gain_hi;
  assign plo     = word_r * gain_lo;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      phi_r <= phi;
      plo_r <= plo;
    end
  end

  // Recombine, drop the fraction, saturate
  assign full = (FULL_W'(phi_r) <<< GAIN_ALIGN) + FULL_W'(plo_r);
  assign y_sh = full >>> OUT_SHIFT;

  always_comb begin
    if (y_sh > OUT_MAX_X) begin
      sample_sat = OUT_MAX_X[SAMPLE_OUT_W-1:0];
    end else if (y_sh < OUT_MIN_X) begin
      sample_sat = OUT_MIN_X[SAMPLE_OUT_W-1:0];
    end else begin
      sample_sat = y_sh[SAMPLE_OUT_W-1:0];
    end
  end

  assign idx_ext = 32'(idx_r);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.sum_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      out_r.sample_out  <= sample_sat;
      out_r.table_index <= idx_ext[INDEX_W-1:0];
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

// ----- hw/rtl/drifting_wavetable_generator_unit.sv -----
`timescale 1ns / 1ps
// Tick beat: the sequencer steps through QUO, REM, MUL and SUM, then registers the result
// on out_valid; SUM waits while the output is stalled. Loads step through QUO and REM and
// give no result. One sequencer runs the index reduction multiply, the single table read
// port and the split gain multiply in turn, one item at a time, each taken from idle.
// Reset: rst_n synchronous, active low; registers take their defaults, then a restart state
// (input stalled) seeds phase and gain. A write to a listed register runs the restart again.

module drifting_wavetable_generator_unit import dwg_pkg::*; #(
  parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH,
  parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS,
  parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  dwg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .sts       (sts),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  dwg_datapath #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/dwg_checker.sv -----
`timescale 1ns / 1ps

module dwg_checker import dwg_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input in_item_t              in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_item_t             out_data,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index
);

  logic tick_beat;
  logic cfg_beat;

  assign tick_beat = in_valid && !in_stall && in_data.func;
  assign cfg_beat  = cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(CFG_COUNT));

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One item at a time: a tick is never followed at once by another beat
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tick_beat |=> in_stall)
    else $error("input taken while a tick is in flight");

  // A fresh result only ever follows a tick by the fixed latency
  a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(tick_beat, 5))
    else $error("result appeared without a matching tick");

  // A register write restarts the sequence before new input is taken
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_beat |=> in_stall && !cfg_ready)
    else $error("no restart cycle after a register write");

endmodule

bind drifting_wavetable_generator_unit dwg_checker u_dwg_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import dwg_pkg::*;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLISTED = 3'd7;

  localparam int FRAC_W        = DEF_PHASE_FRAC_BITS;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int IDLE_PCT      = 13;

  localparam longint OUT_HI  = 8388607;
  localparam longint OUT_LO  = -8388608;
  localparam longint GAIN_HI = (longint'(1) <<< 47) - 1;
  localparam longint GAIN_LO = -(longint'(1) <<< 47);

  localparam logic [RATE_W-1:0] Q48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [RATE_W-1:0] Q48_MIN = 48'h8000_0000_0000;

  // Phase, phase increment and gain of the running playback
  typedef struct packed {
    logic [63:0]              phase;
    logic [63:0]              step;
    logic signed [GAIN_W-1:0] gain;
  } playback_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  drifting_wavetable_generator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow registers, table and playback state
  logic [PERIOD_W-1:0] reg_period = 15'd16384;
  logic [OVER_W-1:0]   reg_over   = 5'd1;
  logic [RATE_W-1:0]   reg_alpha  = '0;
  logic [RATE_W-1:0]   reg_beta   = '0;
  logic [GSTART_W-1:0] reg_gstart = 24'd65536;
  logic [GAIN_W-1:0]   reg_gslope = '0;

  logic signed [VALUE_W-1:0] wave_mem [DEF_TABLE_DEPTH];
  bit                        loaded   [DEF_TABLE_DEPTH];
  playback_t                 play;
  playback_t                 plan;

  in_item_t  pending_beats[$];
  out_item_t expected_samples[$];

  int beats_queued = 0;
  int beats_taken = 0;
  int fail_count = 0;
  int loads_done = 0;
  int ticks_done = 0;
  int reg_writes = 0;
  int settings_tried = 0;
  int in_idle_pct = IDLE_PCT;
  int out_stall_pct = IDLE_PCT;
  int cycle_count = 0;

  function automatic logic [63:0] period_eff();
    if (reg_period == '0) return 64'd1;
    if (reg_period > PERIOD_MAX) return 64'(PERIOD_MAX);
    return 64'(reg_period);
  endfunction

  function automatic logic [63:0] over_eff();
    if (reg_over == '0) return 64'd1;
    if (reg_over > OVER_MAX) return 64'(OVER_MAX);
    return 64'(reg_over);
  endfunction

  // Reduce a signed value into [0, m)
  function automatic logic [63:0] wrap_mod(longint v, logic [63:0] m);
    logic [63:0] r;
    if (v >= 0) return $unsigned(v) % m;
    r = $unsigned(-v) % m;
    return (r == 64'd0) ? 64'd0 : m - r;
  endfunction

  function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] s;
    s = a + b;
    return (s >= m) ? s - m : s;
  endfunction

  function automatic longint as_q48(logic [RATE_W-1:0] r);
    return longint'($signed(r));
  endfunction

  // Sequence start for sample count zero under the current registers
  function automatic playback_t fresh_playback();
    playback_t   s;
    logic [63:0] m;
    m = period_eff() << FRAC_W;
    s.phase = '0;
    s.step = wrap_mod((longint'(1) <<< FRAC_W) + as_q48(reg_alpha) + as_q48(reg_beta), m);
    s.gain = {reg_gstart, {GAIN_ALIGN{1'b0}}};
    return s;
  endfunction

  function automatic logic [INDEX_W-1:0] table_slot(playback_t s);
    logic [63:0] os;
    logic [63:0] fmask;
    logic [63:0] idx;
    os = over_eff();
    fmask = (64'd1 << FRAC_W) - 64'd1;
    idx = (s.phase >> FRAC_W) * os + (((s.phase & fmask) * os) >> FRAC_W);
    return idx[INDEX_W-1:0];
  endfunction

  // Advance phase, second-order step and saturating gain by one sample
  function automatic playback_t next_playback(playback_t s);
    playback_t   n;
    logic [63:0] m;
    longint      g;
    m = period_eff() << FRAC_W;
    n.phase = mod_add(s.phase, s.step, m);
    n.step = mod_add(s.step, wrap_mod(2 * as_q48(reg_beta), m), m);
    g = longint'($signed(s.gain)) + as_q48(reg_gslope);
    if (g > GAIN_HI) g = GAIN_HI;
    else if (g < GAIN_LO) g = GAIN_LO;
    n.gain = g[GAIN_W-1:0];
    return n;
  endfunction

  function automatic logic [SAMPLE_OUT_W-1:0] scaled_sample(logic signed [VALUE_W-1:0] w,
                                                            logic signed [GAIN_W-1:0] g);
    longint p;
    p = (longint'(w) * longint'(g)) >>> OUT_SHIFT;
    if (p > OUT_HI) p = OUT_HI;
    else if (p < OUT_LO) p = OUT_LO;
    return p[SAMPLE_OUT_W-1:0];
  endfunction

  // Update the shadow generator with one accepted beat
  task automatic generator_step(input in_item_t b);
    out_item_t            r;
    logic [INDEX_W-1:0]   slot;
    if (b.func == FUNC_LOAD) begin
      wave_mem[b.table_addr] = b.table_value;
      loads_done++;
    end else begin
      slot = table_slot(play);
      r.table_index = slot;
      r.sample_out = scaled_sample(wave_mem[slot], play.gain);
      expected_samples.push_back(r);
      play = next_playback(play);
      ticks_done++;
    end
  endtask

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PERIOD:      reg_period = data[PERIOD_W-1:0];
      CFG_OVERSAMPLE:  reg_over = data[OVER_W-1:0];
      CFG_RATE_OFFSET: reg_alpha = data[RATE_W-1:0];
      CFG_RATE_DRIFT:  reg_beta = data[RATE_W-1:0];
      CFG_GAIN_START:  reg_gstart = data[GSTART_W-1:0];
      CFG_GAIN_SLOPE:  reg_gslope = data[GAIN_W-1:0];
      default:         return;
    endcase
    play = fresh_playback();
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
    reg_writes++;
  endtask

  task automatic write_settings(input logic [47:0] p, input logic [47:0] o,
                                input logic [47:0] a, input logic [47:0] b,
                                input logic [47:0] gs, input logic [47:0] sl);
    write_reg(CFG_PERIOD, p);
    write_reg(CFG_OVERSAMPLE, o);
    write_reg(CFG_RATE_OFFSET, a);
    write_reg(CFG_RATE_DRIFT, b);
    write_reg(CFG_GAIN_START, gs);
    write_reg(CFG_GAIN_SLOPE, sl);
    settings_tried++;
  endtask

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  // Drift or slope: an extreme, zero, a small value or anything
  function automatic logic [47:0] pick_rate();
    longint s;
    case ($urandom_range(4))
      0: return '0;
      1: return Q48_MAX;
      2: return Q48_MIN;
      3: return rand48();
      default: begin
        s = longint'($signed($urandom()));
        return s[47:0];
      end
    endcase
  endfunction

  // Random settings, mostly short periods so table words get reused
  task automatic random_settings();
    logic [47:0]         junk;
    logic [PERIOD_W-1:0] p;
    logic [OVER_W-1:0]   o;
    logic [GSTART_W-1:0] gs;
    junk = rand48();
    case ($urandom_range(5))
      0: p = '0;
      1: p = PERIOD_W'($urandom_range(8, 1));
      2: p = PERIOD_W'($urandom_range(64, 1));
      3: p = PERIOD_W'(PERIOD_MAX);
      4: p = PERIOD_W'($urandom());
      default: p = PERIOD_W'($urandom_range(512, 1));
    endcase
    o = OVER_W'($urandom());
    case ($urandom_range(3))
      0: gs = 24'h7F_FFFF;
      1: gs = 24'h80_0000;
      2: gs = 24'd65536;
      default: gs = GSTART_W'($urandom());
    endcase
    write_settings({junk[47:PERIOD_W], p}, {junk[47:OVER_W], o}, pick_rate(), pick_rate(),
                   {junk[47:GSTART_W], gs}, pick_rate());
  endtask

  task automatic queue_beat(input in_item_t b);
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_load(input logic [ADDR_W-1:0] addr, input logic [VALUE_W-1:0] value);
    in_item_t b;
    b.func = FUNC_LOAD;
    b.table_addr = addr;
    b.table_value = value;
    queue_beat(b);
    loaded[addr] = 1'b1;
  endtask

  // Queue a tick, loading its table entry first if nothing was written there yet
  task automatic plan_tick();
    in_item_t           b;
    logic [INDEX_W-1:0] slot;
    slot = table_slot(plan);
    if (!loaded[slot]) queue_load(slot, VALUE_W'($urandom()));
    b.func = FUNC_TICK;
    b.table_addr = ADDR_W'($urandom());
    b.table_value = VALUE_W'($urandom());
    queue_beat(b);
    plan = next_playback(plan);
  endtask

  task automatic random_beats(input int count);
    repeat (count) begin
      if ($urandom_range(99) < 55) plan_tick();
      else queue_load(ADDR_W'($urandom()), VALUE_W'($urandom()));
    end
  endtask

  task automatic wait_idle();
    while (beats_taken != beats_queued || expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: predict on acceptance, then offer the next beat or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        generator_step(in_data);
        beats_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted beat with the oldest expected sample
  always @(posedge clk) begin : sample_monitor
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result beat, sample_out %0d, table_index %0d", $time,
                   $signed(out_data.sample_out), out_data.table_index);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_data.sample_out !== want.sample_out) begin
            $display("%0t: sample_out mismatch: expected %0d, actual %0d", $time,
                     $signed(want.sample_out), $signed(out_data.sample_out));
            fail_count++;
          end
          if (out_data.table_index !== want.table_index) begin
            $display("%0t: table_index mismatch: expected %0d, actual %0d", $time,
                     want.table_index, out_data.table_index);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d samples outstanding", cycle_count,
               expected_samples.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : scenario
    int ph;
    play = fresh_playback();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Default registers: unit gain, one entry per sample, extreme words
    plan = play;
    queue_load(14'd0, 16'h8000);
    queue_load(14'd1, 16'h7FFF);
    queue_load(14'd2, 16'hFFFF);
    queue_load(14'd3, 16'h5555);
    queue_load(14'h3FFF, 16'hAAAA);
    queue_load(14'h2AAA, 16'h0000);
    repeat (8) plan_tick();
    wait_idle();

    // Extreme settings first, a write to an unlisted register, then random ones; one phase runs with no idling
    for (ph = 0; ph < 14; ph++) begin
      case (ph)
        0: write_settings(48'd1, 48'd16, '0, '0, 48'h7F_FFFF, '0);
        1: write_settings(48'd0, 48'd0, Q48_MAX, Q48_MIN, 48'h80_0000, Q48_MAX);
        2: write_settings(48'd32767, 48'd31, Q48_MIN, Q48_MAX, 48'd65536, Q48_MIN);
        3: write_settings(48'd16384, 48'd16, '0, '0, 48'd65536, '0);
        4: write_reg(CFG_UNLISTED, rand48());
        default: random_settings();
      endcase
      in_idle_pct   = (ph == 9) ? 0 : IDLE_PCT;
      out_stall_pct = (ph == 9) ? 0 : IDLE_PCT;
      plan = play;
      random_beats((ph == 9) ? 160 : 55);
      wait_idle();
    end

    $display("Run covered %0d table loads and %0d samples over %0d register settings",
             loads_done, ticks_done, settings_tried);
    $display("(%0d register writes, period, oversampling, drift and gain extremes included)",
             reg_writes);
    if (fail_count == 0 && expected_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
